// ===== design/fbcde_pkg.sv =====
// shared types and constants for the block chain directory engine
// no dependencies
package fbcde_pkg;

    localparam int KIND_W = 3;
    localparam int NAME_W = 64;
    localparam int SIZE_W = 21;
    localparam int LINK_W = 12;
    localparam int CFG_W  = 11;
    localparam int STAT_W = 2;

    localparam logic [LINK_W-1:0] LINK_END  = 12'hFFF;
    localparam logic [LINK_W-1:0] LINK_FREE = 12'hFFE;
    localparam logic [CFG_W-1:0]  SEARCH_RESET = 11'd10;

    localparam logic [KIND_W-1:0] KIND_FORMAT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIR_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_DISK_FULL = 2'd3;

    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LOAD,
        DP_CLR_INIT,
        DP_CLR,
        DP_SETUP,
        DP_SRCH_INIT,
        DP_SRCH_RD,
        DP_SRCH_NEXT,
        DP_CREATE,
        DP_WR_LINK,
        DP_WR_END,
        DP_WR_ADD,
        DP_WALK_RD,
        DP_RD_STEP,
        DP_RM_STEP,
        DP_RM_DONE,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic              found;
        logic [STAT_W-1:0] res_status;
        logic              res_bytes;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              found;
        logic              count_zero;
        logic              cur_ok;
        logic              scan_ok;
        logic              rd_free;
        logic              wr_more;
        logic              rd_more;
        logic              steps_ok;
        logic              clr_last;
        logic              out_free;
    } stat_t;

endpackage

// ===== design/fat_block_chain_directory_engine_core.sv =====
// top level of the block chain directory engine
// depends on fbcde_pkg, fbcde_ctrl, fbcde_dp
//
// Request channel in_valid/in_ready carries kind, name_key, dir_flag and
// byte_count; one result transaction (status, bytes_done) follows on
// out_valid/out_ready for every request. One request is worked at a time.
// cfg_we writes cfg_wdata into the first search block register at once;
// write it only while no request is in flight.
// Latency depends on the request: a free-block search inspects one block
// at a time through its read and check states, a read or remove walk steps
// through the chain block by block in the same way, and a write adds each
// block with a search, a link write, an end write and a size update. The
// link table ram has a single registered read port. Each search restarts at
// the first search block, so a write that adds up to TOTAL_BLOCK_COUNT
// blocks searches the table anew for each of them.
// After reset the link table is cleared one entry per cycle; in_ready
// stays low until it is done. Format runs the same pass before its result.
// A result waits in the output register while the receiver stalls, and the
// next request is accepted meanwhile; its own result then waits until the
// register frees.
module fat_block_chain_directory_engine_core
    import fbcde_pkg::*;
#(
    parameter int TOTAL_BLOCK_COUNT = 2048,
    parameter int BLOCK_BYTES       = 512,
    parameter int DIR_SLOTS         = 16,
    parameter int NAME_BITS         = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [NAME_W-1:0] name_key,
    input  logic              dir_flag,
    input  logic [SIZE_W-1:0] byte_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [SIZE_W-1:0] bytes_done,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    cmd_t  cmd;
    stat_t st;

    fbcde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    fbcde_dp #(
        .TOTAL_BLOCK_COUNT (TOTAL_BLOCK_COUNT),
        .BLOCK_BYTES       (BLOCK_BYTES),
        .DIR_SLOTS         (DIR_SLOTS),
        .NAME_BITS         (NAME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .kind         (kind),
        .name_key     (name_key),
        .dir_flag     (dir_flag),
        .byte_count   (byte_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .bytes_done   (bytes_done),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready still high after request accepted");

    a_load_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_LOAD |-> in_valid && in_ready)
        else $error("request latched without handshake");

    a_bytes_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bytes_done != '0 |-> status == ST_OK)
        else $error("byte count reported with error status");

    a_result_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_RESULT |-> !out_valid || out_ready)
        else $error("result overwrote a pending transaction");

endmodule

// ===== design/fbcde_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module fbcde_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/fbcde_dp.sv =====
// datapath: request registers, directory, link table ram, counters, result register
// depends on fbcde_pkg and fbcde_ram
module fbcde_dp
    import fbcde_pkg::*;
#(
    parameter int TOTAL_BLOCK_COUNT = 2048,
    parameter int BLOCK_BYTES       = 512,
    parameter int DIR_SLOTS         = 16,
    parameter int NAME_BITS         = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             st,
    input  logic [KIND_W-1:0] kind,
    input  logic [NAME_W-1:0] name_key,
    input  logic              dir_flag,
    input  logic [SIZE_W-1:0] byte_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [SIZE_W-1:0] bytes_done,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int AW  = $clog2(TOTAL_BLOCK_COUNT);
    localparam int SW  = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
    localparam int STW = $clog2(TOTAL_BLOCK_COUNT + 1);
    localparam logic [LINK_W-1:0] TOTAL_L = LINK_W'(TOTAL_BLOCK_COUNT);
    localparam logic [STW-1:0]    TOTAL_S = STW'(TOTAL_BLOCK_COUNT);
    localparam logic [SIZE_W-1:0] BB      = SIZE_W'(BLOCK_BYTES);

    logic [KIND_W-1:0]    kind_reg;
    logic [NAME_BITS-1:0] key_reg;
    logic                 isdir_reg;
    logic [SIZE_W-1:0]    count_reg;
    logic [CFG_W-1:0]     first_search_reg;

    logic [DIR_SLOTS-1:0] used_reg;
    logic [NAME_BITS-1:0] name_mem  [DIR_SLOTS];
    logic [SIZE_W-1:0]    size_mem  [DIR_SLOTS];
    logic [LINK_W-1:0]    first_mem [DIR_SLOTS];
    logic                 dir_mem   [DIR_SLOTS];

    logic [SW-1:0]     slot_reg;
    logic              found_reg;
    logic [LINK_W-1:0] cur_reg;
    logic [LINK_W-1:0] scan_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] written_reg;
    logic [SIZE_W-1:0] done_reg;
    logic [STW-1:0]    steps_reg;
    logic [AW-1:0]     clr_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [SIZE_W-1:0] bytes_reg;

    logic              free_found;
    logic [SW-1:0]     free_idx;
    logic              match_found;
    logic [SW-1:0]     match_idx;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [LINK_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [LINK_W-1:0] rdata;

    logic [SIZE_W-1:0] wr_left;
    logic [SIZE_W-1:0] rd_left;
    logic [SIZE_W-1:0] wr_chunk;
    logic [SIZE_W-1:0] rd_chunk;

    fbcde_ram #(
        .WIDTH (LINK_W),
        .DEPTH (TOTAL_BLOCK_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // lowest unused slot and lowest matching slot
    always_comb
    begin
        free_found  = 1'b0;
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = DIR_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
            if (used_reg[i] && name_mem[i] == key_reg)
            begin
                match_found = 1'b1;
                match_idx   = SW'(i);
            end
        end
    end

    assign wr_left  = count_reg - written_reg;
    assign rd_left  = size_reg - done_reg;
    assign wr_chunk = (wr_left > BB) ? BB : wr_left;
    assign rd_chunk = (rd_left > BB) ? BB : rd_left;

    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg[AW-1:0];
        wdata = LINK_END;
        raddr = cur_reg[AW-1:0];
        unique case (cmd.op)
            DP_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = (clr_reg < AW'(2)) ? LINK_END : LINK_FREE;
            end
            DP_CREATE:
            begin
                we    = cmd.found;
                waddr = scan_reg[AW-1:0];
            end
            DP_WR_LINK:
            begin
                we    = 1'b1;
                wdata = scan_reg;
            end
            DP_WR_END:
            begin
                we = 1'b1;
            end
            DP_RM_STEP:
            begin
                we    = 1'b1;
                wdata = LINK_FREE;
            end
            DP_SRCH_RD:
            begin
                raddr = scan_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_search_reg <= SEARCH_RESET;
            used_reg         <= '0;
            out_valid_reg    <= 1'b0;
            clr_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                first_search_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && cmd.op != DP_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                DP_CLR_INIT:
                begin
                    clr_reg  <= '0;
                    used_reg <= '0;
                end
                DP_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                DP_CREATE:
                begin
                    used_reg[slot_reg] <= 1'b1;
                end
                DP_RM_DONE:
                begin
                    used_reg[slot_reg] <= 1'b0;
                end
                DP_RESULT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                kind_reg  <= kind;
                key_reg   <= name_key[NAME_BITS-1:0];
                isdir_reg <= dir_flag;
                count_reg <= byte_count;
            end
            DP_SETUP:
            begin
                slot_reg    <= (kind_reg == KIND_CREATE) ? free_idx : match_idx;
                found_reg   <= (kind_reg == KIND_CREATE) ? free_found : match_found;
                cur_reg     <= first_mem[match_idx];
                size_reg    <= size_mem[match_idx];
                written_reg <= '0;
                done_reg    <= '0;
                steps_reg   <= '0;
            end
            DP_SRCH_INIT:
            begin
                scan_reg <= LINK_W'(first_search_reg);
            end
            DP_SRCH_NEXT:
            begin
                scan_reg <= scan_reg + LINK_W'(1);
            end
            DP_CREATE:
            begin
                name_mem[slot_reg]  <= key_reg;
                size_mem[slot_reg]  <= '0;
                first_mem[slot_reg] <= cmd.found ? scan_reg : LINK_END;
                dir_mem[slot_reg]   <= isdir_reg;
            end
            DP_WR_LINK:
            begin
                cur_reg <= scan_reg;
            end
            DP_WR_ADD:
            begin
                written_reg        <= written_reg + wr_chunk;
                size_mem[slot_reg] <= written_reg + wr_chunk;
            end
            DP_RD_STEP:
            begin
                done_reg  <= done_reg + rd_chunk;
                cur_reg   <= rdata;
                steps_reg <= steps_reg + STW'(1);
            end
            DP_RM_STEP:
            begin
                cur_reg   <= rdata;
                steps_reg <= steps_reg + STW'(1);
            end
            DP_RESULT:
            begin
                status_reg <= cmd.res_status;
                bytes_reg  <= cmd.res_bytes ? done_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.kind       = kind_reg;
        st.found      = found_reg;
        st.count_zero = (count_reg == '0);
        st.cur_ok     = (cur_reg < TOTAL_L);
        st.scan_ok    = (scan_reg < TOTAL_L);
        st.rd_free    = (rdata == LINK_FREE);
        st.wr_more    = (written_reg < count_reg);
        st.rd_more    = (done_reg < count_reg) && (done_reg < size_reg);
        st.steps_ok   = (steps_reg < TOTAL_S);
        st.clr_last   = (clr_reg == AW'(TOTAL_BLOCK_COUNT - 1));
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign bytes_done = bytes_reg;

endmodule

// ===== design/fbcde_ctrl.sv =====
// controller state machine sequencing clear, search, chain write, walk and free
// depends on fbcde_pkg
module fbcde_ctrl
    import fbcde_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLR_INIT,
        S_CLR,
        S_IDLE,
        S_DECODE,
        S_ROUTE,
        S_SRCH_INIT,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_WR_END,
        S_WR_ADD,
        S_WR_CHK,
        S_RD_ISSUE,
        S_RD_CHK,
        S_RM_ISSUE,
        S_RM_CHK,
        S_RM_DONE,
        S_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic              fmt_reg, fmt_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic              res_bytes_reg, res_bytes_next;

    always_comb
    begin
        state_next      = state_reg;
        fmt_next        = fmt_reg;
        res_status_next = res_status_reg;
        res_bytes_next  = res_bytes_reg;
        cmd.op          = DP_IDLE;
        cmd.found       = 1'b0;
        cmd.res_status  = res_status_reg;
        cmd.res_bytes   = res_bytes_reg;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_CLR_INIT:
            begin
                cmd.op     = DP_CLR_INIT;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                cmd.op = DP_CLR;
                if (st.clr_last)
                begin
                    fmt_next        = 1'b0;
                    res_status_next = ST_OK;
                    res_bytes_next  = 1'b0;
                    state_next      = fmt_reg ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_status_next = ST_OK;
                res_bytes_next  = 1'b0;
                priority if (st.kind == KIND_FORMAT)
                begin
                    fmt_next   = 1'b1;
                    state_next = S_CLR_INIT;
                end
                else if (st.kind == KIND_CREATE || st.kind == KIND_WRITE ||
                         st.kind == KIND_READ || st.kind == KIND_REMOVE)
                begin
                    cmd.op     = DP_SETUP;
                    state_next = S_ROUTE;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_ROUTE:
            begin
                priority if (st.kind == KIND_CREATE)
                begin
                    if (st.found)
                    begin
                        state_next = S_SRCH_INIT;
                    end
                    else
                    begin
                        res_status_next = ST_DIR_FULL;
                        state_next      = S_RESULT;
                    end
                end
                else if (!st.found)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_RESULT;
                end
                else if (st.kind == KIND_WRITE)
                begin
                    priority if (st.count_zero)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (!st.cur_ok)
                    begin
                        res_status_next = ST_DISK_FULL;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_WR_ADD;
                    end
                end
                else if (st.kind == KIND_READ)
                begin
                    state_next = S_RD_ISSUE;
                end
                else
                begin
                    state_next = S_RM_ISSUE;
                end
            end
            S_SRCH_INIT:
            begin
                cmd.op     = DP_SRCH_INIT;
                state_next = S_SRCH_RD;
            end
            S_SRCH_RD:
            begin
                if (st.scan_ok)
                begin
                    cmd.op     = DP_SRCH_RD;
                    state_next = S_SRCH_CHK;
                end
                else if (st.kind == KIND_CREATE)
                begin
                    cmd.op     = DP_CREATE;
                    state_next = S_RESULT;
                end
                else
                begin
                    res_status_next = ST_DISK_FULL;
                    state_next      = S_RESULT;
                end
            end
            S_SRCH_CHK:
            begin
                priority if (!st.rd_free)
                begin
                    cmd.op     = DP_SRCH_NEXT;
                    state_next = S_SRCH_RD;
                end
                else if (st.kind == KIND_CREATE)
                begin
                    cmd.op     = DP_CREATE;
                    cmd.found  = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = DP_WR_LINK;
                    state_next = S_WR_END;
                end
            end
            S_WR_END:
            begin
                cmd.op     = DP_WR_END;
                state_next = S_WR_ADD;
            end
            S_WR_ADD:
            begin
                cmd.op     = DP_WR_ADD;
                state_next = S_WR_CHK;
            end
            S_WR_CHK:
            begin
                state_next = st.wr_more ? S_SRCH_INIT : S_RESULT;
            end
            S_RD_ISSUE:
            begin
                if (st.cur_ok && st.rd_more && st.steps_ok)
                begin
                    cmd.op     = DP_WALK_RD;
                    state_next = S_RD_CHK;
                end
                else
                begin
                    res_bytes_next = 1'b1;
                    state_next     = S_RESULT;
                end
            end
            S_RD_CHK:
            begin
                if (st.rd_free)
                begin
                    res_bytes_next = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.op     = DP_RD_STEP;
                    state_next = S_RD_ISSUE;
                end
            end
            S_RM_ISSUE:
            begin
                if (st.cur_ok && st.steps_ok)
                begin
                    cmd.op     = DP_WALK_RD;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    state_next = S_RM_DONE;
                end
            end
            S_RM_CHK:
            begin
                if (st.rd_free)
                begin
                    state_next = S_RM_DONE;
                end
                else
                begin
                    cmd.op     = DP_RM_STEP;
                    state_next = S_RM_ISSUE;
                end
            end
            S_RM_DONE:
            begin
                cmd.op     = DP_RM_DONE;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR_INIT;
            fmt_reg        <= 1'b0;
            res_status_reg <= ST_OK;
            res_bytes_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fmt_reg        <= fmt_next;
            res_status_reg <= res_status_next;
            res_bytes_reg  <= res_bytes_next;
        end
    end

endmodule
